@@ design/rnt_pkg.sv @@
// Package for the ring neighbour table next-hop unit.
// Field widths, operation and register codes, table entry, result and
// controller/datapath command and status types. No dependencies.
package rnt_pkg;

  localparam int unsigned ID_W      = 64;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned LAT_W     = 20;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 64;

  // Operation codes of an input word
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Lookup selection modes
  localparam logic MODE_WORST   = 1'b0;
  localparam logic MODE_CLOSEST = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MY_ID       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOOKUP_MODE = CFG_IDX_W'(1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
    logic [LAT_W-1:0]  lat;
  } entry_t;

  typedef struct packed {
    logic              evicted;
    logic [LAT_W-1:0]  evicted_latency;
    logic              found;
    logic [ID_W-1:0]   hop_id;
    logic [ADDR_W-1:0] hop_addr;
  } res_t;

  typedef enum logic [1:0] {
    WR_SRC_INPUT,
    WR_SRC_RDATA,
    WR_SRC_HELD
  } wr_src_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    latch_in;
    logic    scan_rd;
    logic    rd_en;
    logic    wr_en;
    wr_src_e wr_src;
    logic    decide;
    logic    load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_op;
    logic held_op;
    logic evict_new;
    logic out_free;
  } st_t;

endpackage

@@ design/rnt_in_if.sv @@
// Input channel of the ring neighbour table: valid/ready plus one request word.
// Depends on rnt_pkg.
interface rnt_in_if
  import rnt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [ID_W-1:0]   node_id;
  logic [ADDR_W-1:0] node_addr;
  logic [LAT_W-1:0]  latency;
  logic [ID_W-1:0]   key;

  modport source (output valid, operation, node_id, node_addr, latency, key, input ready);
  modport sink   (input valid, operation, node_id, node_addr, latency, key, output ready);
endinterface

@@ design/rnt_out_if.sv @@
// Result channel of the ring neighbour table: valid/ready plus one result word.
// Depends on rnt_pkg.
interface rnt_out_if
  import rnt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              evicted;
  logic [LAT_W-1:0]  evicted_latency;
  logic              found;
  logic [ID_W-1:0]   hop_id;
  logic [ADDR_W-1:0] hop_addr;

  modport source (output valid, evicted, evicted_latency, found, hop_id, hop_addr,
                  input ready);
  modport sink   (input valid, evicted, evicted_latency, found, hop_id, hop_addr,
                  output ready);
endinterface

@@ design/rnt_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on rnt_pkg.
interface rnt_cfg_if
  import rnt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/rnt_ctrl.sv @@
// Controller of the ring neighbour table: sequencer state, entry count and
// scan/shift address counters. Depends on rnt_pkg.
module rnt_ctrl
  import rnt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  st_t  st_i,
  input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] worst_idx_i,
  output cmd_t cmd_o,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr_o,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] wr_addr_o
);

  localparam int unsigned IW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_e        state_d, state_q;
  logic [CW-1:0] count_d, count_q;
  logic [IW-1:0] idx_d, idx_q;
  logic [IW-1:0] ptr_d, ptr_q;
  logic          in_fire, full, idx_last, ptr_last;

  assign in_fire  = (state_q == ST_IDLE) && st_i.in_valid;
  assign full     = count_q == CW'(CAPACITY);
  assign idx_last = idx_q == IW'(count_q - CW'(1));
  assign ptr_last = ptr_q == IW'(CAPACITY - 1);

  // Next state and counters
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    ptr_d   = ptr_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (in_fire) begin
          if (st_i.in_op == OP_LOOKUP) begin
            state_d = (count_q == '0) ? ST_FINISH : ST_SCAN;
          end else if (full) begin
            state_d = ST_SCAN;
          end else begin
            count_d = count_q + CW'(1);
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + IW'(1);
        if (idx_last) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = (st_i.held_op == OP_LOOKUP) ? ST_FINISH : ST_DECIDE;
      end
      ST_DECIDE: begin
        ptr_d   = worst_idx_i;
        state_d = st_i.evict_new ? ST_FINISH : ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        state_d = ptr_last ? ST_APPEND : ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        ptr_d   = ptr_q + IW'(1);
        state_d = ST_SHIFT_RD;
      end
      ST_APPEND: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (st_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o     = '0;
    cmd_o.wr_src = WR_SRC_INPUT;
    rd_addr_o = idx_q;
    wr_addr_o = count_q[IW-1:0];
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.latch_in = in_fire;
        cmd_o.wr_en    = in_fire && (st_i.in_op == OP_INSERT) && !full;
      end
      ST_SCAN: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.scan_rd = 1'b1;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
      end
      ST_SHIFT_RD: begin
        cmd_o.rd_en = !ptr_last;
        rd_addr_o   = ptr_q + IW'(1);
      end
      ST_SHIFT_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_SRC_RDATA;
        wr_addr_o    = ptr_q;
      end
      ST_APPEND: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_src = WR_SRC_HELD;
        wr_addr_o    = IW'(CAPACITY - 1);
      end
      ST_FINISH: begin
        cmd_o.load_out = st_i.out_free;
      end
      default: begin
        cmd_o.in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      ptr_q   <= ptr_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_lookup_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && st_i.in_op == OP_LOOKUP) |=> $stable(count_q))
    else $error("lookup changed entry count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CW'(idx_q) < count_q))
    else $error("scan address beyond filled entries");
`endif

endmodule

@@ design/rnt_dpath.sv @@
// Datapath of the ring neighbour table: entry memory, held request, scan
// compare/select, configuration registers and result register. Depends on rnt_pkg.
module rnt_dpath
  import rnt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  rnt_in_if.sink    in_i,
  rnt_out_if.source out_o,
  rnt_cfg_if.sink   cfg_i,
  input  cmd_t cmd_i,
  input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] rd_addr_i,
  input  logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] wr_addr_i,
  output st_t  st_o,
  output logic [(CAPACITY > 1 ? $clog2(CAPACITY) : 1)-1:0] worst_idx_o
);

  localparam int unsigned IW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;

  // Held request word
  logic              op_q;
  logic [ID_W-1:0]   id_q, key_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LAT_W-1:0]  lat_q;

  // Configuration
  logic [ID_W-1:0] my_id_q;
  logic            mode_q;

  // Entry memory with registered read
  entry_t        tbl_q [CAPACITY];
  entry_t        rdata_q, wdata;
  logic          scan_vld_q;
  logic [IW-1:0] scan_idx_q;

  // Running selection
  logic              have_q;
  logic [LAT_W-1:0]  best_lat_q;
  logic [ID_W-1:0]   best_dist_q;
  logic [IW-1:0]     pick_idx_q;
  logic [ID_W-1:0]   pick_id_q;
  logic [ADDR_W-1:0] pick_addr_q;
  logic              evicted_q;
  logic [LAT_W-1:0]  evict_lat_q;

  // Result register
  logic out_valid_q;
  res_t out_q, res_d;

  logic            match, cand, by_lat, better, take, found;
  logic [ID_W-1:0] ring_dist;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = cmd_i.in_ready;

  assign st_o.in_valid  = in_i.valid;
  assign st_o.in_op     = in_i.operation;
  assign st_o.held_op   = op_q;
  assign st_o.evict_new = lat_q > best_lat_q;
  assign st_o.out_free  = !out_valid_q || out_o.ready;
  assign worst_idx_o    = pick_idx_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      my_id_q <= '0;
      mode_q  <= MODE_CLOSEST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_MY_ID:       my_id_q <= cfg_i.data;
        CFG_LOOKUP_MODE: mode_q  <= cfg_i.data[0];
        default:         ;
      endcase
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q   <= in_i.operation;
      id_q   <= in_i.node_id;
      addr_q <= in_i.node_addr;
      lat_q  <= in_i.latency;
      key_q  <= in_i.key;
    end
  end

  // Memory write data select
  always_comb begin
    case (cmd_i.wr_src)
      WR_SRC_INPUT: wdata = '{id: in_i.node_id, addr: in_i.node_addr, lat: in_i.latency};
      WR_SRC_RDATA: wdata = rdata_q;
      WR_SRC_HELD:  wdata = '{id: id_q, addr: addr_q, lat: lat_q};
      default:      wdata = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      tbl_q[wr_addr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= tbl_q[rd_addr_i];
    end
    if (cmd_i.scan_rd) begin
      scan_idx_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_vld_q <= 1'b0;
    end else begin
      scan_vld_q <= cmd_i.scan_rd;
    end
  end

  // Scan compare: interval (my_id, key] wraps when my_id >= key
  always_comb begin
    if (my_id_q < key_q) begin
      match = (rdata_q.id > my_id_q) && (rdata_q.id <= key_q);
    end else begin
      match = (rdata_q.id > my_id_q) || (rdata_q.id <= key_q);
    end
    ring_dist = key_q - rdata_q.id;
    cand      = (op_q == OP_LOOKUP) ? match : 1'b1;
    by_lat    = (op_q == OP_INSERT) || (mode_q == MODE_WORST);
    better    = !have_q || (by_lat ? (rdata_q.lat > best_lat_q) : (ring_dist < best_dist_q));
    take      = scan_vld_q && cand && better;
  end

  // Running best; an insert scan tracks the first highest latency
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_lat_q  <= rdata_q.lat;
      best_dist_q <= ring_dist;
      pick_idx_q  <= scan_idx_q;
      pick_id_q   <= rdata_q.id;
      pick_addr_q <= rdata_q.addr;
    end
    if (cmd_i.decide) begin
      evict_lat_q <= st_o.evict_new ? lat_q : best_lat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q    <= 1'b0;
      evicted_q <= 1'b0;
    end else if (cmd_i.latch_in) begin
      have_q    <= 1'b0;
      evicted_q <= 1'b0;
    end else begin
      if (take) begin
        have_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        evicted_q <= 1'b1;
      end
    end
  end

  // Result word; worst-latency mode needs a latency above zero
  always_comb begin
    found = (op_q == OP_LOOKUP) && have_q &&
            !((mode_q == MODE_WORST) && (best_lat_q == '0));
    res_d.evicted         = evicted_q;
    res_d.evicted_latency = evicted_q ? evict_lat_q : '0;
    res_d.found           = found;
    res_d.hop_id          = found ? pick_id_q : '0;
    res_d.hop_addr        = found ? pick_addr_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.evicted         = out_q.evicted;
  assign out_o.evicted_latency = out_q.evicted_latency;
  assign out_o.found           = out_q.found;
  assign out_o.hop_id          = out_q.hop_id;
  assign out_o.hop_addr        = out_q.hop_addr;

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |-> (out_q.hop_id == '0 && out_q.hop_addr == '0))
    else $error("hop fields set without a hit");

  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.found && out_q.evicted))
    else $error("result both found and evicted");
`endif

endmodule

@@ design/ring_neighbor_table_next_hop_unit.sv @@
// Ring neighbour table next-hop unit, top level. A lookup scans the filled entries
// before its result is loaded; an insert into a non-full table writes the entry on
// acceptance; an insert into a full table scans, then shifts entries (a read state
// and a write state per shifted entry) and appends the new one unless it is evicted.
// One word in flight; the next is accepted the cycle after its result is loaded.
// Reset empties the table (count 0), my_id 0, lookup mode closest; no clearing pass.
module ring_neighbor_table_next_hop_unit
  import rnt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rnt_in_if.sink    in_i,
  rnt_out_if.source out_o,
  rnt_cfg_if.sink   cfg_i
);

  localparam int unsigned IW = CAPACITY > 1 ? $clog2(CAPACITY) : 1;

  cmd_t          cmd;
  st_t           st;
  logic [IW-1:0] rd_addr, wr_addr, worst_idx;

  rnt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .st_i        (st),
    .worst_idx_i (worst_idx),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr)
  );

  rnt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_i       (cfg_i),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .st_o        (st),
    .worst_idx_o (worst_idx)
  );

endmodule
